[rtl/bmhq_pkg.sv]
// Package for the binary max-heap queue: sizes, operation and status codes,
// payload structs and controller command/status structs.
// No dependencies; bmhq_ctrl, bmhq_dp and the top level import it, bmhq_ram does not.
`default_nettype none

package bmhq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = ADDR_W + 2;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 7;

    localparam logic       FUNC_INSERT = 1'b0;
    localparam logic       FUNC_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] removed_key;
        logic signed [KEY_W-1:0] top_key;
        logic [CNT_W-1:0]        count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic up_step;
        logic up_cmp;
        logic last_cap;
        logic dn_step;
        logic dn_cmp;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic rej;
        logic ins;
        logic one_left;
        logic pos_zero;
        logic up_stop;
        logic dn_leaf;
        logic dn_stop;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/bmhq_ram.sv]
// Generic single-write, dual-read memory with registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[rtl/bmhq_ctrl.sv]
// Controller state machine of the heap queue: sequences accept, sift-up,
// sift-down and result hand-off. Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire bmhq_pkg::t_stat i_stat,
    output bmhq_pkg::t_cmd      o_cmd
);
    import bmhq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_UP_RD    = 8'b0000_0010,
        S_UP_CMP   = 8'b0000_0100,
        S_LAST_CAP = 8'b0000_1000,
        S_DN_RD    = 8'b0001_0000,
        S_DN_CMP   = 8'b0010_0000,
        S_DONE     = 8'b0100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.rej) begin
                        n_state = S_DONE;
                    end else if (i_stat.ins) begin
                        n_state = S_UP_RD;
                    end else if (i_stat.one_left) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LAST_CAP;
                    end
                end
            end
            S_UP_RD: begin
                o_cmd.up_step = 1'b1;
                n_state = i_stat.pos_zero ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state = i_stat.up_stop ? S_DONE : S_UP_RD;
            end
            S_LAST_CAP: begin
                o_cmd.last_cap = 1'b1;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_step = 1'b1;
                n_state = i_stat.dn_leaf ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state = i_stat.dn_stop ? S_DONE : S_DN_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/bmhq_dp.sv]
// Datapath of the heap queue: heap memory, hole key and position, count,
// capacity, root shadow and the output register. Depends on bmhq_pkg, bmhq_ram.
`default_nettype none

module bmhq_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bmhq_pkg::t_in_item         i_in_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [bmhq_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire bmhq_pkg::t_cmd             i_cmd,
    output bmhq_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output bmhq_pkg::t_out_item             o_out_item
);
    import bmhq_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        r_cap;
    logic [CNT_W-1:0]        limit;
    logic [ADDR_W-1:0]       r_pos;
    logic [ADDR_W-1:0]       n_pos;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic signed [KEY_W-1:0] r_top;
    logic signed [KEY_W-1:0] r_removed;
    logic [1:0]              r_status;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr_a;
    logic [KEY_W-1:0]        ram_rdata_a;
    logic [KEY_W-1:0]        ram_rdata_b;
    logic signed [KEY_W-1:0] val_a;
    logic signed [KEY_W-1:0] val_b;

    logic [ADDR_W-1:0]       pos_m1;
    logic [ADDR_W-1:0]       par;
    logic [IDX_W-1:0]        lch;
    logic [IDX_W-1:0]        rch;
    logic [IDX_W-1:0]        cnt_x;
    logic                    full;
    logic                    empty;
    logic                    rej;
    logic                    up_go;
    logic                    go_l;
    logic                    go_r;
    logic signed [KEY_W-1:0] big_lk;

    assign val_a = $signed(ram_rdata_a);
    assign val_b = $signed(ram_rdata_b);

    assign limit  = (r_cap < DEPTH_C) ? r_cap : DEPTH_C;
    assign full   = (r_count >= limit);
    assign empty  = (r_count == '0);
    assign rej    = (i_in_item.func == FUNC_INSERT) ? full : empty;

    // Parent and child indices of the hole.
    assign pos_m1 = r_pos - ADDR_W'(1);
    assign par    = pos_m1 >> 1;
    assign lch    = {1'b0, r_pos, 1'b1};
    assign rch    = lch + IDX_W'(1);
    assign cnt_x  = IDX_W'(r_count);

    assign up_go  = (r_key > val_a);
    assign go_l   = (r_key < val_a);
    assign big_lk = go_l ? val_a : r_key;
    assign go_r   = (rch < cnt_x) && (big_lk < val_b);

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = r_key;
        ram_raddr_a = pos_m1;
        n_pos       = r_pos;
        n_key       = r_key;
        n_count     = r_count;
        // In idle the A port reads the last entry ahead of a remove.
        ram_raddr_a = ADDR_W'(r_count - CNT_W'(1));
        if (i_cmd.accept) begin
            n_key = i_in_item.key;
            if (!rej) begin
                if (i_in_item.func == FUNC_INSERT) begin
                    n_pos   = r_count[ADDR_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
        if (i_cmd.up_step) begin
            ram_raddr_a = par;
            ram_we      = (r_pos == '0);
        end
        if (i_cmd.up_cmp) begin
            ram_we = 1'b1;
            if (up_go) begin
                ram_wdata = val_a;
                n_pos     = par;
            end
        end
        if (i_cmd.last_cap) begin
            n_key = val_a;
            n_pos = '0;
        end
        if (i_cmd.dn_step) begin
            ram_raddr_a = lch[ADDR_W-1:0];
            ram_we      = (lch >= cnt_x);
        end
        if (i_cmd.dn_cmp) begin
            ram_we = 1'b1;
            if (go_r) begin
                ram_wdata = val_b;
                n_pos     = rch[ADDR_W-1:0];
            end else if (go_l) begin
                ram_wdata = val_a;
                n_pos     = lch[ADDR_W-1:0];
            end
        end
    end

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (rch[ADDR_W-1:0]),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_key <= n_key;
        if (ram_we && (ram_waddr == '0)) begin
            r_top <= $signed(ram_wdata);
        end
        if (i_cmd.accept) begin
            r_removed <= '0;
            if (i_in_item.func == FUNC_INSERT) begin
                r_status <= full ? ST_FULL : ST_DONE;
            end else begin
                r_status <= empty ? ST_EMPTY : ST_DONE;
                if (!empty) begin
                    r_removed <= r_top;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out.status      <= r_status;
            r_out.removed_key <= r_removed;
            r_out.top_key     <= empty ? '0 : r_top;
            r_out.count       <= r_count;
        end
    end

    assign o_stat.rej      = rej;
    assign o_stat.ins      = (i_in_item.func == FUNC_INSERT);
    assign o_stat.one_left = (r_count == CNT_W'(1));
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.up_stop  = !up_go;
    assign o_stat.dn_leaf  = (lch >= cnt_x);
    assign o_stat.dn_stop  = !go_r && !go_l;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

[rtl/binary_max_heap_queue_top.sv]
// Top level of the binary max-heap priority queue.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_dp (and through it bmhq_ram).
//
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_item) carries one item per
// operation: func selects insert or remove-maximum, key is the signed key to
// insert. The output channel (o_out_valid, i_out_stall, o_out_item) returns
// exactly one item per input item, in order: status, removed root, the new
// top key and the entry count.
// The capacity register is written through i_cfg_we and i_cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Inserts are rejected once the count reaches the smaller of capacity and the memory depth.
// Steps: an insert is accepted in idle, then climbs one level per memory read state (S_UP_RD)
// and compare/write state (S_UP_CMP) until it reaches the root or stops lower; a remove
// captures the last entry as the hole key (S_LAST_CAP) and then sinks it one level per
// read state (S_DN_RD) and compare/write state (S_DN_CMP) until it reaches a leaf or stops
// above its children. Rejected items and a remove of the last entry go straight to S_DONE.
// The block works on one item at a time; o_in_stall is low only in idle.
// A finished result sits in an output register, so the next item is accepted
// while that result is still stalled. A result that completes while the
// previous one is still stalled waits in the controller until the register
// frees up. Reset empties the heap, sets capacity to 64 and drops any pending
// result; the memory contents are not cleared and need no clearing pass.
`default_nettype none

module binary_max_heap_queue_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire bmhq_pkg::t_in_item         i_in_item,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output bmhq_pkg::t_out_item             o_out_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [bmhq_pkg::CNT_W-1:0] i_cfg_wdata
);
    import bmhq_pkg::*;

    // Command and status bundles between the controller and the datapath.
    t_cmd  cmd;
    t_stat stat;

    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bmhq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[dv/binary_max_heap_queue_top_tb.sv]
// Self-checking testbench for binary_max_heap_queue_top: directed table, then random traffic
// under several capacity settings, checked against a behavioral max-heap predictor or typed-in results.
// Depends on bmhq_pkg and the RTL under rtl/; needs nothing else.

module binary_max_heap_queue_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic [CNT_W-1:0]        CAP_TOP = 7'd127;

    // Run control. The watchdog limit sits well above a full run with its random gaps, stalls,
    // the pressure hold-off and the configuration pauses.
    localparam int LIMIT_CYCLES    = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_AT     = 120;
    localparam int PRESSURE_CYCLES = 300;
    localparam int CALM_FIRST      = 300;
    localparam int CALM_LAST       = 380;
    localparam int MAX_REPORTS     = 10;

    // One line of the directed table: either a capacity write or an item. Items whose result
    // is obvious carry it typed in; the rest are checked against the predictor.
    typedef struct {
        logic             is_cfg;
        logic [CNT_W-1:0] cap;
        t_in_item         item;
        logic             typed;
        t_out_item        exp;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_item;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    // Predictor state: a private copy of the heap, its fill level and the capacity setting.
    logic signed [KEY_W-1:0] model_heap [DEPTH];
    int                      model_cnt;
    int                      model_cap;

    t_out_item expected_q [$];
    t_dir_row  dir_rows [$];
    int        items_sent;
    int        err_cnt;
    int        cycle_cnt;

    binary_max_heap_queue_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one item to the heap copy and returns the result the block must give for it.
    // An insert appends and climbs while strictly greater than its parent; a remove moves
    // the last entry to the root and sinks it toward the larger child, left on a tie.
    function automatic t_out_item heap_predict(input t_in_item it);
        t_out_item               res;
        int                      limit;
        int                      pos;
        int                      par;
        int                      big;
        int                      lc;
        int                      rc;
        logic signed [KEY_W-1:0] tmp;
        res = '0;
        res.status = ST_DONE;
        limit = (model_cap < DEPTH) ? model_cap : DEPTH;
        if (it.func == FUNC_INSERT) begin
            if (model_cnt >= limit) begin
                res.status = ST_FULL;
            end else begin
                pos = model_cnt;
                model_heap[pos] = it.key;
                model_cnt++;
                while (pos > 0) begin
                    par = (pos - 1) / 2;
                    if (model_heap[pos] <= model_heap[par]) break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[par];
                    model_heap[par] = tmp;
                    pos = par;
                end
            end
        end else if (model_cnt == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.removed_key = model_heap[0];
            model_cnt--;
            if (model_cnt > 0) begin
                model_heap[0] = model_heap[model_cnt];
                pos = 0;
                while (pos < model_cnt) begin
                    big = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < model_cnt && model_heap[big] < model_heap[lc]) big = lc;
                    if (rc < model_cnt && model_heap[big] < model_heap[rc]) big = rc;
                    if (big == pos) break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[big];
                    model_heap[big] = tmp;
                    pos = big;
                end
            end
        end
        res.top_key = (model_cnt > 0) ? model_heap[0] : '0;
        res.count = CNT_W'(model_cnt);
        return res;
    endfunction

    // Random idling of either side, about 7 times in 100. Inside the calm window (counted in
    // items sent) neither side idles, so the block runs back to back for a while.
    function automatic logic take_break();
        if (items_sent >= CALM_FIRST && items_sent < CALM_LAST) return 1'b0;
        return $urandom_range(0, 99) < 7;
    endfunction

    task automatic log_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%s", msg);
    endtask

    task automatic add_op(input logic func, input logic signed [KEY_W-1:0] key,
                          input logic typed, input t_out_item exp);
        t_dir_row row;
        row.is_cfg = 1'b0;
        row.cap = '0;
        row.item.func = func;
        row.item.key = key;
        row.typed = typed;
        row.exp = exp;
        dir_rows.push_back(row);
    endtask

    task automatic add_cap(input logic [CNT_W-1:0] cap);
        t_dir_row row;
        row.is_cfg = 1'b1;
        row.cap = cap;
        row.item = '0;
        row.typed = 1'b0;
        row.exp = '0;
        dir_rows.push_back(row);
    endtask

    // Offers one item on the input channel. Inputs change on the falling edge; the handshake
    // is sampled on the rising edge. The prediction is made at the moment of acceptance so the
    // heap copy follows the exact order in which the block takes items.
    task automatic push_item(input t_in_item it, input logic typed, input t_out_item exp);
        t_out_item pred;
        @(negedge i_clk);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pred = heap_predict(it);
        expected_q.push_back(typed ? exp : pred);
        items_sent++;
    endtask

    // Capacity is only changed with the block idle: the input channel is dropped and every
    // outstanding result has been taken before the write enable is raised for one cycle.
    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_cap = cap;
    endtask

    // Result checker: every accepted result is compared against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                log_error($sformatf("ERROR: result with nothing expected: st=%0d rm=%h top=%h n=%0d",
                                    o_out_item.status, o_out_item.removed_key,
                                    o_out_item.top_key, o_out_item.count));
            end else begin
                want = expected_q.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.removed_key !== want.removed_key ||
                    o_out_item.top_key !== want.top_key ||
                    o_out_item.count !== want.count) begin
                    log_error($sformatf({"ERROR: mismatch exp st=%0d rm=%h top=%h n=%0d",
                                         " got st=%0d rm=%h top=%h n=%0d"},
                                        want.status, want.removed_key, want.top_key,
                                        want.count, o_out_item.status,
                                        o_out_item.removed_key, o_out_item.top_key,
                                        o_out_item.count));
                end
            end
        end
    end

    // Result receiver. Once, after enough items have gone in, it holds stall high for a long
    // stretch while the sender keeps offering, so the output register and the pending slot
    // fill and the block has to stall its input. Otherwise it stalls at random.
    initial begin : result_sink
        int held;
        held = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (held < PRESSURE_CYCLES && items_sent >= PRESSURE_AT) begin
                i_out_stall <= 1'b1;
                held++;
            end else begin
                i_out_stall <= take_break();
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int                      phase_cap [6];
        int                      phase_len [6];
        int                      phase_ins [6];
        int                      p;
        int                      n;
        t_in_item                it;
        logic signed [KEY_W-1:0] key;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        items_sent  = 0;
        err_cnt     = 0;
        model_cnt   = 0;
        model_cap   = CAP_RESET;
        for (int i = 0; i < DEPTH; i++) model_heap[i] = '0;

        // Directed table. Reset state first: the heap is empty and capacity is 64.
        add_op(FUNC_REMOVE, KEY_MAX, 1'b1, {ST_EMPTY, 32'sd0, 32'sd0, 7'd0});
        add_op(FUNC_INSERT, KEY_MAX, 1'b1, {ST_DONE, 32'sd0, KEY_MAX, 7'd1});
        add_op(FUNC_INSERT, KEY_MIN, 1'b1, {ST_DONE, 32'sd0, KEY_MAX, 7'd2});
        add_op(FUNC_INSERT, 32'sd0, 1'b0, '0);
        add_op(FUNC_INSERT, -32'sd1, 1'b0, '0);
        // Three equal keys exercise the tie rules on both the climb and the sink.
        add_op(FUNC_INSERT, 32'sd5, 1'b0, '0);
        add_op(FUNC_INSERT, 32'sd5, 1'b0, '0);
        add_op(FUNC_INSERT, 32'sd5, 1'b0, '0);
        // Drain all seven; the last remove takes the final entry and reports an empty heap.
        for (int i = 0; i < 7; i++) add_op(FUNC_REMOVE, KEY_MIN, 1'b0, '0);
        add_op(FUNC_REMOVE, 32'sd0, 1'b1, {ST_EMPTY, 32'sd0, 32'sd0, 7'd0});
        // Capacity zero rejects every insert.
        add_cap(7'd0);
        add_op(FUNC_INSERT, 32'sd1, 1'b1, {ST_FULL, 32'sd0, 32'sd0, 7'd0});
        // Capacity one: a second insert is rejected and leaves the contents alone.
        add_cap(7'd1);
        add_op(FUNC_INSERT, KEY_MIN, 1'b1, {ST_DONE, 32'sd0, KEY_MIN, 7'd1});
        add_op(FUNC_INSERT, KEY_MAX, 1'b1, {ST_FULL, 32'sd0, KEY_MIN, 7'd1});
        add_op(FUNC_REMOVE, KEY_MAX, 1'b1, {ST_DONE, KEY_MIN, 32'sd0, 7'd0});

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) set_capacity(dir_rows[r].cap);
            else push_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].exp);
        end

        // Random phases. The first uses a capacity above the memory depth and leans on
        // inserts so the heap reaches 64 entries and hits the depth limit; later phases
        // drain it, run at the smallest capacities and finish at an arbitrary setting.
        phase_cap = '{CAP_TOP, 64, 0, 1, 3, $urandom_range(2, 126)};
        phase_len = '{180, 100, 20, 40, 60, 100};
        phase_ins = '{70, 30, 50, 50, 50, 55};
        for (p = 0; p < 6; p++) begin
            set_capacity(CNT_W'(phase_cap[p]));
            for (n = 0; n < phase_len[p]; n++) begin
                // Keys: extremes, a narrow band around zero for ties, and full-range values.
                case ($urandom_range(0, 9))
                    0: key = KEY_MAX;
                    1: key = KEY_MIN;
                    2, 3, 4: key = int'($urandom_range(0, 8)) - 4;
                    default: key = $urandom;
                endcase
                it.func = ($urandom_range(0, 99) < phase_ins[p]) ? FUNC_INSERT : FUNC_REMOVE;
                it.key = key;
                push_item(it, 1'b0, '0);
            end
        end

        // Wait for every outstanding result, then a little longer to catch stray outputs.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_q.size() != 0) log_error("ERROR: expected results never arrived");
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/bmhq_dp.sv
rtl/binary_max_heap_queue_top.sv
dv/binary_max_heap_queue_top_tb.sv
